// ===== hw/rtl/socc_pkg.sv =====
// Shared types, op codes and sizing constants for the sprite column occlusion clip core.
package socc_pkg;

   // Default table size and screen width
   localparam int MAX_SEGMENTS_DEF = 256;
   localparam int SCREEN_WIDTH_DEF = 320;

   // Slot and count width; covers the largest table size (1024 plus one)
   localparam int CNT_W = 11;

   // Fixed payload widths
   localparam int OP_W   = 2;
   localparam int SEG_W  = 8;
   localparam int COL_W  = 9;
   localparam int ROW_W  = 16;

   // Clip top value that disables a segment at a column
   localparam logic signed [ROW_W-1:0] NO_CLIP_MARK = 16'sh7FFF;

   // Op codes
   localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
   localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
   localparam logic [OP_W-1:0] OP_WRITE  = 2'd2;
   localparam logic [OP_W-1:0] OP_QUERY  = 2'd3;

   // Status codes
   localparam logic STATUS_OK      = 1'b0;
   localparam logic STATUS_REFUSED = 1'b1;

   // Token handed from cell to cell along the chain
   typedef struct packed {
      logic                    vld;
      logic [OP_W-1:0]         op;
      logic [CNT_W-1:0]        tgt;        // slot targeted by append or clip write
      logic [CNT_W-1:0]        cnt;        // segment count seen at entry
      logic [COL_W-1:0]        col;
      logic                    on_screen;
      logic [COL_W-1:0]        span_start;
      logic [COL_W-1:0]        span_end;
      logic signed [ROW_W-1:0] row_a;      // wall top or running visible top
      logic signed [ROW_W-1:0] row_b;      // wall bottom or running visible bottom
      logic                    hit;        // fully covered, no further trimming
      logic                    status;
   } token_type;

endpackage

// ===== hw/rtl/socc_if.sv =====
// Valid/ready channel interfaces for the request and response sides.
interface socc_req_if;
   logic                                  valid;
   logic                                  ready;
   logic [socc_pkg::OP_W-1:0]             op;
   logic [socc_pkg::SEG_W-1:0]            seg_index;
   logic [socc_pkg::COL_W-1:0]            column;
   logic [socc_pkg::COL_W-1:0]            span_start;
   logic [socc_pkg::COL_W-1:0]            span_end;
   logic signed [socc_pkg::ROW_W-1:0]     wall_top;
   logic signed [socc_pkg::ROW_W-1:0]     wall_bottom;
   logic signed [socc_pkg::ROW_W-1:0]     sprite_top;
   logic signed [socc_pkg::ROW_W-1:0]     sprite_bottom;

   modport source (output valid, op, seg_index, column, span_start, span_end,
                   wall_top, wall_bottom, sprite_top, sprite_bottom,
                   input ready);
   modport sink   (input valid, op, seg_index, column, span_start, span_end,
                   wall_top, wall_bottom, sprite_top, sprite_bottom,
                   output ready);
endinterface

interface socc_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [socc_pkg::ROW_W-1:0]     visible_top;
   logic signed [socc_pkg::ROW_W-1:0]     visible_bottom;
   logic                                  status;

   modport source (output valid, visible_top, visible_bottom, status, input ready);
   modport sink   (input valid, visible_top, visible_bottom, status, output ready);
endinterface

// ===== hw/rtl/socc_cell.sv =====
// One segment slot of the chain: span registers, per-column clip memory and trim logic.
module socc_cell #(
   parameter int IDX          = 0,
   parameter int SCREEN_WIDTH = socc_pkg::SCREEN_WIDTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  socc_pkg::token_type  tok_in,
   output socc_pkg::token_type  tok_out
);
   import socc_pkg::*;

   localparam int ADDR_W = $clog2(SCREEN_WIDTH);
   localparam logic [CNT_W-1:0] MY_SLOT = CNT_W'(IDX);

   token_type               tok_ff;
   logic [COL_W-1:0]        start_ff;
   logic [COL_W-1:0]        end_ff;
   logic [2*ROW_W-1:0]      mem_ff [SCREEN_WIDTH];
   logic [2*ROW_W-1:0]      rd_ff;

   logic [ADDR_W+COL_W-1:0] col_ext;
   logic [ADDR_W-1:0]       addr_in;
   logic                    mine;

   // Memory address and slot match come from the incoming token
   assign col_ext = {{ADDR_W{1'b0}}, tok_in.col};
   assign addr_in = col_ext[ADDR_W-1:0];
   assign mine    = tok_in.vld && (tok_in.status == STATUS_OK) && (tok_in.tgt == MY_SLOT);

   // Token register
   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.vld <= 1'b0;
      end else if (advance) begin
         tok_ff <= tok_in;
      end
   end

   // Span registers, loaded by an append aimed at this slot
   always_ff @(posedge clock) begin
      if (advance && mine && (tok_in.op == OP_APPEND)) begin
         start_ff <= tok_in.span_start;
         end_ff   <= tok_in.span_end;
      end
   end

   // Clip memory: written on entry, so a query behind the write sees new data
   always_ff @(posedge clock) begin
      if (advance && mine && (tok_in.op == OP_WRITE)) begin
         mem_ff[addr_in] <= {tok_in.row_a, tok_in.row_b};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rd_ff <= mem_ff[addr_in];
      end
   end

   // Trim stage
   logic signed [ROW_W-1:0] wt;
   logic signed [ROW_W-1:0] wb;
   logic signed [ROW_W-1:0] vt_mid;
   logic                    apply;

   assign wt = rd_ff[2*ROW_W-1:ROW_W];
   assign wb = rd_ff[ROW_W-1:0];

   assign apply = tok_ff.vld && (tok_ff.op == OP_QUERY) && !tok_ff.hit && tok_ff.on_screen
                  && (MY_SLOT < tok_ff.cnt)
                  && (tok_ff.col >= start_ff) && (tok_ff.col < end_ff)
                  && (wt != NO_CLIP_MARK);

   always_comb begin
      tok_out = tok_ff;
      vt_mid  = tok_ff.row_a;
      if (apply) begin
         if ((wt <= tok_ff.row_a) && (wb >= tok_ff.row_b)) begin
            // full cover: hidden
            tok_out.row_a = 16'sd1;
            tok_out.row_b = 16'sd0;
            tok_out.hit   = 1'b1;
         end else begin
            // top trim first, bottom trim sees the new top
            if ((wt <= tok_ff.row_a) && (wb > tok_ff.row_a) && (wb < tok_ff.row_b)) begin
               vt_mid = wb + 16'sd1;
            end
            tok_out.row_a = vt_mid;
            if ((wb >= tok_ff.row_b) && (wt < tok_ff.row_b) && (wt > vt_mid)) begin
               tok_out.row_b = wt - 16'sd1;
            end
         end
      end
   end

endmodule

// ===== hw/rtl/sprite_column_occlusion_clip_core.sv =====
// Top level: entry checks, segment count, chain of segment cells and response register.
//
//   channel  | dir | handshake     | payload
//   req_ch   | in  | valid/ready   | op, seg_index, column, span, wall rows, sprite rows
//   rsp_ch   | out | valid/ready   | visible_top, visible_bottom, status
//
// One item enters per cycle while the response register is free or being drained; each
// result passes through the chain of cells (one cell per segment slot) and then
// the response register. Results come out in request order.
// Reset clears the segment count and the valid bits of the chain; spans and clips
// hold whatever was last written.
// A stalled response freezes the whole chain, and the request side with it.
module sprite_column_occlusion_clip_core #(
   parameter int MAX_SEGMENTS = socc_pkg::MAX_SEGMENTS_DEF,
   parameter int SCREEN_WIDTH = socc_pkg::SCREEN_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   socc_req_if.sink    req_ch,
   socc_rsp_if.source  rsp_ch
);
   import socc_pkg::*;

   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SEGMENTS);

   logic [CNT_W-1:0]        count_ff;
   logic [CNT_W-1:0]        count_in;
   logic                    advance;
   logic                    accept;
   logic                    on_screen;
   logic [CNT_W-1:0]        seg_ext;
   token_type               tok_entry;
   token_type               chain [MAX_SEGMENTS+1];

   logic                    rsp_vld_ff;
   logic signed [ROW_W-1:0] rsp_top_ff;
   logic signed [ROW_W-1:0] rsp_bot_ff;
   logic                    rsp_status_ff;

   // Chain moves whenever the response register is free or being drained
   assign advance      = !rsp_vld_ff || rsp_ch.ready;
   assign req_ch.ready = advance;
   assign accept       = req_ch.valid && advance;

   assign on_screen = ({{(32-COL_W){1'b0}}, req_ch.column} < 32'(SCREEN_WIDTH));
   assign seg_ext   = CNT_W'(req_ch.seg_index);

   // Entry token: slot selection and refusal decided against the current count
   always_comb begin
      tok_entry            = '0;
      tok_entry.vld        = req_ch.valid;
      tok_entry.op         = req_ch.op;
      tok_entry.cnt        = count_ff;
      tok_entry.col        = req_ch.column;
      tok_entry.on_screen  = on_screen;
      tok_entry.span_start = req_ch.span_start;
      tok_entry.span_end   = req_ch.span_end;
      tok_entry.row_a      = req_ch.wall_top;
      tok_entry.row_b      = req_ch.wall_bottom;
      tok_entry.hit        = 1'b0;
      tok_entry.status     = STATUS_OK;
      count_in             = count_ff;
      unique case (req_ch.op)
         OP_CLEAR: begin
            count_in = '0;
         end
         OP_APPEND: begin
            tok_entry.tgt = count_ff;
            if (count_ff >= MAX_CNT) begin
               tok_entry.status = STATUS_REFUSED;
            end else begin
               count_in = count_ff + CNT_W'(1);
            end
         end
         OP_WRITE: begin
            tok_entry.tgt = seg_ext;
            if ((seg_ext >= count_ff) || !on_screen) begin
               tok_entry.status = STATUS_REFUSED;
            end
         end
         OP_QUERY: begin
            tok_entry.row_a = req_ch.sprite_top;
            tok_entry.row_b = req_ch.sprite_bottom;
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   // Segment count
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (accept) begin
         count_ff <= count_in;
      end
   end

   assign chain[0] = tok_entry;

   // Chain of segment cells
   for (genvar d = 0; d < MAX_SEGMENTS; d++) begin : g_cell
      socc_cell #(
         .IDX          (d),
         .SCREEN_WIDTH (SCREEN_WIDTH)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .tok_in  (chain[d]),
         .tok_out (chain[d+1])
      );
   end

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (advance) begin
         rsp_vld_ff <= chain[MAX_SEGMENTS].vld;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_status_ff <= chain[MAX_SEGMENTS].status;
         if (chain[MAX_SEGMENTS].op == OP_QUERY) begin
            rsp_top_ff <= chain[MAX_SEGMENTS].row_a;
            rsp_bot_ff <= chain[MAX_SEGMENTS].row_b;
         end else begin
            rsp_top_ff <= '0;
            rsp_bot_ff <= '0;
         end
      end
   end

   assign rsp_ch.valid          = rsp_vld_ff;
   assign rsp_ch.visible_top    = rsp_top_ff;
   assign rsp_ch.visible_bottom = rsp_bot_ff;
   assign rsp_ch.status         = rsp_status_ff;

endmodule

// ===== tb/sv/sprite_column_occlusion_clip_core_tb.sv =====
// Self-checking testbench for the sprite column occlusion clip core.
`timescale 1ns / 100ps

module sprite_column_occlusion_clip_core_tb;
   import socc_pkg::*;

   localparam int MAX_SEG   = MAX_SEGMENTS_DEF;
   localparam int SCREEN_W  = SCREEN_WIDTH_DEF;
   localparam int ROW_HI    = 32767;
   localparam int ROW_LO    = -32768;
   localparam int ITEM_GOAL = 1650;
   localparam int CHAIN_LAT = MAX_SEG + 2;
   localparam int LIMIT     = 400000;

   // One request as queued for the driver
   typedef struct {
      logic [OP_W-1:0]         op;
      logic [SEG_W-1:0]        seg_index;
      logic [COL_W-1:0]        column;
      logic [COL_W-1:0]        span_start;
      logic [COL_W-1:0]        span_end;
      logic signed [ROW_W-1:0] wall_top;
      logic signed [ROW_W-1:0] wall_bottom;
      logic signed [ROW_W-1:0] sprite_top;
      logic signed [ROW_W-1:0] sprite_bottom;
      bit                      drain_first;   // launch only once all answers are back
   } clip_cmd_type;

   typedef struct {
      logic signed [ROW_W-1:0] top;
      logic signed [ROW_W-1:0] bottom;
      logic                    status;
   } clip_ans_type;

   logic clock;
   logic reset;

   socc_req_if req_ch();
   socc_rsp_if rsp_ch();

   sprite_column_occlusion_clip_core i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // Occluder table as the block should hold it
   int                      seg_total;
   logic [COL_W-1:0]        slot_start  [MAX_SEG];
   logic [COL_W-1:0]        slot_end    [MAX_SEG];
   logic signed [ROW_W-1:0] clip_top    [MAX_SEG][SCREEN_W];
   logic signed [ROW_W-1:0] clip_bottom [MAX_SEG][SCREEN_W];

   // Table as seen by the stimulus planner: keeps queries off unwritten clips
   int                      plan_cnt;
   logic [COL_W-1:0]        plan_start   [MAX_SEG];
   logic [COL_W-1:0]        plan_end     [MAX_SEG];
   bit                      plan_written [MAX_SEG][SCREEN_W];
   bit                      drain_next;

   clip_cmd_type backlog[$];
   clip_ans_type answers_due[$];

   int total_cmds;
   int answers_checked;
   int mismatch_count;
   int n_query;
   int n_hidden;
   int n_refused;
   int cycle_count;

   // Apply one request to the table and work out the answer it yields
   function automatic clip_ans_type occlude_step(clip_cmd_type c);
      clip_ans_type a;
      int        vt;
      int        vb;
      int        wt;
      int        wb;
      int        d;
      a.top    = '0;
      a.bottom = '0;
      a.status = STATUS_OK;
      case (c.op)
         OP_CLEAR: begin
            seg_total = 0;
         end
         OP_APPEND: begin
            if (seg_total >= MAX_SEG) begin
               a.status = STATUS_REFUSED;
            end else begin
               slot_start[seg_total] = c.span_start;
               slot_end[seg_total]   = c.span_end;
               seg_total++;
            end
         end
         OP_WRITE: begin
            if (c.seg_index >= seg_total || c.column >= SCREEN_W) begin
               a.status = STATUS_REFUSED;
            end else begin
               clip_top[c.seg_index][c.column]    = c.wall_top;
               clip_bottom[c.seg_index][c.column] = c.wall_bottom;
            end
         end
         default: begin
            vt = c.sprite_top;
            vb = c.sprite_bottom;
            n_query++;
            if (c.column < SCREEN_W) begin
               for (d = 0; d < seg_total; d++) begin
                  if (c.column < slot_start[d] || c.column >= slot_end[d]) continue;
                  wt = clip_top[d][c.column];
                  wb = clip_bottom[d][c.column];
                  if (wt == NO_CLIP_MARK) continue;
                  // wall spans the whole sprite column
                  if (wt <= vt && wb >= vb) begin
                     vt = 1;
                     vb = 0;
                     n_hidden++;
                     break;
                  end
                  if (wt <= vt && wb > vt && wb < vb) vt = wb + 1;
                  if (wb >= vb && wt < vb && wt > vt) vb = wt - 1;
               end
            end
            a.top    = vt[ROW_W-1:0];
            a.bottom = vb[ROW_W-1:0];
         end
      endcase
      if (a.status == STATUS_REFUSED) n_refused++;
      return a;
   endfunction

   function automatic int rand_in(int lo, int hi);
      return lo + int'($urandom_range(hi - lo));
   endfunction

   function automatic int sat_row(int v);
      if (v > ROW_HI) return ROW_HI;
      if (v < ROW_LO) return ROW_LO;
      return v;
   endfunction

   // Per-item wait: none, full spread, or mostly none
   function automatic int draw_wait(int mode);
      case (mode)
         0:       return 0;
         1:       return $urandom_range(11);
         default: return ($urandom_range(7) == 0) ? $urandom_range(11) : 0;
      endcase
   endfunction

   // Unused fields carry random noise
   function automatic clip_cmd_type new_cmd(logic [OP_W-1:0] op);
      clip_cmd_type c;
      c.op            = op;
      c.seg_index     = SEG_W'($urandom);
      c.column        = COL_W'($urandom);
      c.span_start    = COL_W'($urandom);
      c.span_end      = COL_W'($urandom);
      c.wall_top      = ROW_W'($urandom);
      c.wall_bottom   = ROW_W'($urandom);
      c.sprite_top    = ROW_W'($urandom);
      c.sprite_bottom = ROW_W'($urandom);
      c.drain_first   = 1'b0;
      return c;
   endfunction

   // A query is safe if every live segment covering its column has a written clip
   function automatic bit query_ok(int col);
      int d;
      if (col >= SCREEN_W) return 1'b1;
      for (d = 0; d < plan_cnt; d++) begin
         if (col >= plan_start[d] && col < plan_end[d] && !plan_written[d][col]) return 1'b0;
      end
      return 1'b1;
   endfunction

   task automatic plan_push(clip_cmd_type c);
      c.drain_first = drain_next;
      drain_next    = 1'b0;
      case (c.op)
         OP_CLEAR: plan_cnt = 0;
         OP_APPEND: begin
            if (plan_cnt < MAX_SEG) begin
               plan_start[plan_cnt] = c.span_start;
               plan_end[plan_cnt]   = c.span_end;
               plan_cnt++;
            end
         end
         OP_WRITE: begin
            if (c.seg_index < plan_cnt && c.column < SCREEN_W)
               plan_written[c.seg_index][c.column] = 1'b1;
         end
         default: ;
      endcase
      backlog.push_back(c);
      total_cmds++;
   endtask

   task automatic push_clear();
      plan_push(new_cmd(OP_CLEAR));
   endtask

   task automatic push_append(int s, int e);
      clip_cmd_type c;
      c            = new_cmd(OP_APPEND);
      c.span_start = COL_W'(s);
      c.span_end   = COL_W'(e);
      plan_push(c);
   endtask

   task automatic push_write(int seg, int col, int top, int bottom);
      clip_cmd_type c;
      c             = new_cmd(OP_WRITE);
      c.seg_index   = SEG_W'(seg);
      c.column      = COL_W'(col);
      c.wall_top    = ROW_W'(top);
      c.wall_bottom = ROW_W'(bottom);
      plan_push(c);
   endtask

   // Falls back to an off-screen column when the chosen one would read unwritten clips
   task automatic push_query(int col, int top, int bottom);
      clip_cmd_type c;
      c = new_cmd(OP_QUERY);
      if (!query_ok(col)) col = rand_in(SCREEN_W, 511);
      c.column        = COL_W'(col);
      c.sprite_top    = ROW_W'(top);
      c.sprite_bottom = ROW_W'(bottom);
      plan_push(c);
   endtask

   // Clip pair near a scene's row band, now and then no-clip or full range
   task automatic push_clip(int seg, int col, int base);
      int pick;
      int top;
      pick = $urandom_range(19);
      if (pick == 0) begin
         push_write(seg, col, NO_CLIP_MARK, $urandom);
      end else if (pick == 1) begin
         push_write(seg, col, $urandom, $urandom);
      end else begin
         top = sat_row(base + rand_in(-60, 60));
         push_write(seg, col, top, sat_row(top + rand_in(-10, 100)));
      end
   endtask

   task automatic push_look(int col, int base);
      int top;
      if ($urandom_range(19) == 0) begin
         push_query(col, $signed(ROW_W'($urandom)), $signed(ROW_W'($urandom)));
      end else begin
         top = sat_row(base + rand_in(-80, 60));
         push_query(col, top, sat_row(top + rand_in(-10, 160)));
      end
   endtask

   // Clock and reset; all block inputs known from time zero
   always #4 clock = ~clock;

   initial begin
      clock                = 1'b0;
      reset                = 1'b1;
      req_ch.valid         = 1'b0;
      req_ch.op            = OP_CLEAR;
      req_ch.seg_index     = '0;
      req_ch.column        = '0;
      req_ch.span_start    = '0;
      req_ch.span_end      = '0;
      req_ch.wall_top      = '0;
      req_ch.wall_bottom   = '0;
      req_ch.sprite_top    = '0;
      req_ch.sprite_bottom = '0;
      rsp_ch.ready         = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
   end

   // Driver: offers queued requests, honors drain points and random gaps
   clip_cmd_type on_bus;
   int        send_gap;
   int        send_mode;
   int        sent_cnt;

   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         send_gap  = 0;
         send_mode = 1;
         sent_cnt  = 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            answers_due.push_back(occlude_step(on_bus));
            sent_cnt++;
            if (sent_cnt % 45 == 0) send_mode = $urandom_range(2);
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_ch.valid <= 1'b0;
            end else if (backlog.size() > 0 &&
                         !(backlog[0].drain_first && answers_due.size() > 0)) begin
               on_bus = backlog.pop_front();
               req_ch.op            <= on_bus.op;
               req_ch.seg_index     <= on_bus.seg_index;
               req_ch.column        <= on_bus.column;
               req_ch.span_start    <= on_bus.span_start;
               req_ch.span_end      <= on_bus.span_end;
               req_ch.wall_top      <= on_bus.wall_top;
               req_ch.wall_bottom   <= on_bus.wall_bottom;
               req_ch.sprite_top    <= on_bus.sprite_top;
               req_ch.sprite_bottom <= on_bus.sprite_bottom;
               req_ch.valid         <= 1'b1;
               send_gap = draw_wait(send_mode);
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each response transfer, drives ready with stalls
   clip_ans_type want;
   int        rsp_wait;
   int        recv_mode;
   int        long_stall;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         rsp_wait   = 0;
         recv_mode  = 1;
         long_stall = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (answers_due.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected response: top %0d bottom %0d status %0d",
                           rsp_ch.visible_top, rsp_ch.visible_bottom, rsp_ch.status);
            end else begin
               want = answers_due.pop_front();
               if (rsp_ch.visible_top !== want.top || rsp_ch.visible_bottom !== want.bottom ||
                   rsp_ch.status !== want.status) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("response %0d: expected top %0d bottom %0d status %0d, %s %0d %0d %0d",
                              answers_checked, want.top, want.bottom, want.status,
                              "got top/bottom/status", rsp_ch.visible_top,
                              rsp_ch.visible_bottom, rsp_ch.status);
               end
            end
            answers_checked++;
            if (answers_checked % 40 == 0) recv_mode = $urandom_range(2);
            rsp_wait = draw_wait(recv_mode);
            // long back-pressure: the chain fills and the request side stalls
            if (answers_checked == 250 || answers_checked == 1100) long_stall = 700;
         end
         if (long_stall > 0) begin
            long_stall--;
            rsp_ch.ready <= 1'b0;
         end else if (rsp_wait > 0) begin
            rsp_wait--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == LIMIT) begin
         $display("sprite_column_occlusion_clip_core_tb: done, errors");
         $finish;
      end
   end

   // Stimulus plan, then wait for the last answer
   initial begin
      int  k;
      int  c;
      int  q;
      int  s;
      int  e;
      int  nseg;
      int  nq;
      int  w0;
      int  wn;
      int  fc;
      int  base;
      int  first_slot;
      bit  filled;
      logic [OP_W-1:0] pick_op;

      seg_total       = 0;
      plan_cnt        = 0;
      drain_next      = 1'b0;
      total_cmds      = 0;
      answers_checked = 0;
      mismatch_count  = 0;
      n_query         = 0;
      n_hidden        = 0;
      n_refused       = 0;
      cycle_count     = 0;
      filled          = 1'b0;

      // Directed: empty table, refusals, span shapes, each trim, off-screen, slot reuse
      push_query(0, 10, 20);
      push_write(0, 0, 5, 9);
      push_append(0, 320);
      push_append(100, 100);
      push_append(320, 0);
      push_write(0, 10, 0, 100);
      push_write(0, 319, NO_CLIP_MARK, ROW_LO);
      push_write(3, 5, 0, 0);
      push_write(0, 320, 0, 0);
      push_query(10, 10, 20);
      push_query(319, ROW_LO, ROW_HI);
      push_write(0, 20, ROW_LO, 15);
      push_query(20, 10, 30);
      push_write(0, 30, 25, ROW_HI);
      push_query(30, 10, 30);
      push_query(400, ROW_LO, ROW_HI);
      push_query(511, 7, -7);
      push_write(0, 40, 12, 18);
      push_query(40, 10, 30);
      push_clear();
      push_query(10, 50, 60);
      push_append(0, 20);
      push_query(10, 50, 60);
      push_query(319, 0, 0);

      drain_next = 1'b1;
      while (total_cmds < ITEM_GOAL) begin
         if (!filled && total_cmds > 600) begin
            // Full table: 256 segments, a few around one column, then refused appends
            filled     = 1'b1;
            drain_next = 1'b1;
            push_clear();
            fc   = rand_in(0, SCREEN_W - 1);
            base = rand_in(-100, 300);
            for (k = 0; k < MAX_SEG; k++) begin
               if ($urandom_range(6) == 0) begin
                  s = rand_in(0, fc);
                  e = rand_in(fc + 1, SCREEN_W);
               end else begin
                  s = rand_in(0, SCREEN_W);
                  e = rand_in(0, s);
               end
               push_append(s, e);
            end
            for (k = 0; k < 3; k++) push_append(rand_in(0, 320), rand_in(0, 320));
            for (k = 0; k < MAX_SEG; k++) begin
               if (plan_start[k] <= fc && fc < plan_end[k]) push_clip(k, fc, base);
            end
            push_clip(MAX_SEG - 1, rand_in(0, SCREEN_W - 1), base);
            for (q = 0; q < 12; q++) push_look(fc, base);
            for (q = 0; q < 4; q++) push_look(rand_in(0, 511), base);
         end else if ($urandom_range(99) < 12) begin
            // Noise: any op with random content
            nq = rand_in(3, 8);
            for (q = 0; q < nq; q++) begin
               pick_op = OP_W'($urandom);
               case (pick_op)
                  OP_CLEAR:  push_clear();
                  OP_APPEND: push_append(rand_in(0, 320), rand_in(0, 320));
                  OP_WRITE:  push_write($urandom_range(255), $urandom_range(511),
                                        $urandom, $urandom);
                  default:   push_look($urandom_range(511), rand_in(-200, 300));
               endcase
            end
         end else begin
            // Scene: a few segments over a narrow column window, clips, then queries
            if ($urandom_range(5) == 0) drain_next = 1'b1;
            if ($urandom_range(9) < 7 || plan_cnt > MAX_SEG - 10) push_clear();
            first_slot = plan_cnt;
            nseg = rand_in(1, 6);
            wn   = rand_in(1, 4);
            if ($urandom_range(7) == 0)
               w0 = $urandom_range(1) ? 0 : SCREEN_W - wn;
            else
               w0 = rand_in(0, SCREEN_W - wn);
            base = rand_in(-100, 300);
            for (k = 0; k < nseg; k++) begin
               case ($urandom_range(9))
                  0: begin s = 0; e = SCREEN_W; end
                  1: begin s = rand_in(0, 320); e = rand_in(0, s); end
                  2: begin s = rand_in(0, 320); e = rand_in(s, 320); end
                  default: begin
                     s = w0 - rand_in(0, 30);
                     e = w0 + wn + rand_in(0, 30);
                     if (s < 0) s = 0;
                     if (e > SCREEN_W) e = SCREEN_W;
                  end
               endcase
               push_append(s, e);
            end
            for (k = first_slot; k < plan_cnt; k++) begin
               for (c = w0; c < w0 + wn; c++) begin
                  if (plan_start[k] <= c && c < plan_end[k] && $urandom_range(9) != 0)
                     push_clip(k, c, base);
               end
            end
            nq = rand_in(3, 10);
            for (q = 0; q < nq; q++) begin
               k = $urandom_range(99);
               if (k < 72)      c = w0 + rand_in(0, wn - 1);
               else if (k < 86) c = rand_in(0, SCREEN_W - 1);
               else             c = rand_in(SCREEN_W, 511);
               push_look(c, base);
               // occasional refused clip write: index past the count or column off screen
               if ($urandom_range(11) == 0) begin
                  if (plan_cnt < MAX_SEG)
                     push_write(rand_in(plan_cnt, MAX_SEG - 1), rand_in(0, SCREEN_W - 1),
                                $urandom, $urandom);
                  else
                     push_write(rand_in(0, MAX_SEG - 1), rand_in(SCREEN_W, 511),
                                $urandom, $urandom);
               end
            end
         end
      end

      wait (!reset);
      while (answers_checked < total_cmds) @(posedge clock);
      repeat (CHAIN_LAT + 40) @(posedge clock);

      $display("%0d transfers checked: %0d queries, %0d hidden by a full cover, %0d refused",
               answers_checked, n_query, n_hidden, n_refused);
      if (mismatch_count == 0 && answers_due.size() == 0) begin
         $display("sprite_column_occlusion_clip_core_tb: done, clean");
      end else begin
         $display("%0d mismatches, %0d answers outstanding", mismatch_count, answers_due.size());
         $display("sprite_column_occlusion_clip_core_tb: done, errors");
      end
      $finish;
   end

endmodule
